[hdl/pnaf_pkg.sv]
// Shared types and constants for the plane normalize and axis filter block.
package pnaf_pkg;

  localparam int unsigned CoefW = 32;
  localparam int unsigned AxisW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SlotW = 8;

  typedef enum logic [1:0] {
    MODE_ALL  = 2'd0,
    MODE_PAR  = 2'd1,
    MODE_PERP = 2'd2,
    MODE_ALT  = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE   = 3'd0,
    REG_AXIS_X = 3'd1,
    REG_AXIS_Y = 3'd2,
    REG_AXIS_Z = 3'd3,
    REG_COS    = 3'd4,
    REG_SIN    = 3'd5,
    REG_RSV6   = 3'd6,
    REG_RSV7   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DIVIDE,
    ST_DOT,
    ST_DONE
  } state_t;

endpackage

[hdl/pnaf_if.sv]
// Handshake channel interfaces for plane items, result items and register writes.
interface pnaf_plane_if;
  logic                                valid;
  logic                                ready;
  logic signed [pnaf_pkg::CoefW-1:0]   coef_a;
  logic signed [pnaf_pkg::CoefW-1:0]   coef_b;
  logic signed [pnaf_pkg::CoefW-1:0]   coef_c;
  logic signed [pnaf_pkg::CoefW-1:0]   coef_d;
  logic                                last_plane;
  modport source (output valid, coef_a, coef_b, coef_c, coef_d, last_plane, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, coef_d, last_plane, output ready);
endinterface

interface pnaf_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pnaf_pkg::CoefW-1:0]   norm_a;
  logic signed [pnaf_pkg::CoefW-1:0]   norm_b;
  logic signed [pnaf_pkg::CoefW-1:0]   norm_c;
  logic signed [pnaf_pkg::CoefW-1:0]   norm_d;
  logic                                kept;
  logic [pnaf_pkg::SlotW-1:0]          slot;
  logic                                degenerate;
  logic                                last_out;
  modport source (output valid, norm_a, norm_b, norm_c, norm_d, kept, slot, degenerate,
                  last_out, input ready);
  modport sink (input valid, norm_a, norm_b, norm_c, norm_d, kept, slot, degenerate,
                last_out, output ready);
endinterface

interface pnaf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pnaf_pkg::CfgIdxW-1:0]        index;
  logic [pnaf_pkg::CfgDataW-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/plane_normalize_axis_filter.sv]
// Plane normalizer and axis filter: sequencer around one shared multiplier, with separate add/compare logic.
//
//  channel    | dir | handshake     | payload
//  plane_in   | in  | valid/ready   | coef_a..coef_d, last_plane
//  plane_out  | out | valid/ready   | norm_a..norm_d, kept, slot, degenerate, last_out
//  cfg        | in  | valid/ready   | index, data (always ready)
//
// An item passes through the squares on the multiplier, a binary square root one root
// bit a cycle, four restoring divisions one quotient bit a cycle on one subtractor for
// all four, then the dot product on the multiplier.
// A zero-length normal skips to the result after the squares.
// Reset (rst, synchronous) clears the sequencer, slot count and registers to defaults.
// A stalled result holds in the output register; the next item is taken meanwhile.
module plane_normalize_axis_filter #(
  parameter int unsigned MAX_PLANES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  pnaf_plane_if.sink           plane_in,
  pnaf_result_if.source        plane_out,
  pnaf_cfg_if.sink             cfg
);

  localparam int unsigned CntW = $clog2(MAX_PLANES + 1);

  pnaf_pkg::state_t state, state_next;

  logic [1:0]                  filter_mode;
  logic signed [15:0]          axis [3];
  logic [15:0]                 cos_limit;
  logic [15:0]                 sin_limit;
  logic [CntW-1:0]             kept_count;

  logic signed [32:0]          coef [4];
  logic                        last_hold;
  logic [4:0]                  step;
  logic [1:0]                  op;
  logic                        degen;

  logic signed [32:0]          mul_a, mul_b;
  logic signed [65:0]          prod;
  logic [63:0]                 sumsq;
  logic [63:0]                 sum_total;

  logic [63:0]                 sq_val;
  logic [34:0]                 sq_rem;
  logic [31:0]                 root;
  logic [34:0]                 sq_try;
  logic [34:0]                 sq_trial;

  logic [32:0]                 dv_rem;
  logic [30:0]                 dv_low;
  logic [30:0]                 quo;
  logic                        dv_sat;
  logic                        dv_neg;
  logic [32:0]                 dv_try;
  logic                        dv_ge;
  logic signed [32:0]          dv_x;
  logic [31:0]                 dv_mag;
  logic [62:0]                 dv_num;
  logic [31:0]                 dv_result;

  logic signed [31:0]          res [4];
  logic signed [47:0]          dot;
  logic [47:0]                 dot_abs;
  logic                        pass;

  logic                        take_in;
  logic                        out_free;
  logic                        load_out;

  // control decode
  always_comb begin
    out_free = !plane_out.valid || plane_out.ready;
    plane_in.ready = (state == pnaf_pkg::ST_IDLE);
    load_out = (state == pnaf_pkg::ST_DONE) && out_free;
  end

  assign take_in = plane_in.valid && plane_in.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      pnaf_pkg::ST_IDLE:   if (take_in) state_next = pnaf_pkg::ST_SQUARE;
      pnaf_pkg::ST_SQUARE: if (step == 5'd3) begin
        state_next = (sum_total == 64'd0) ? pnaf_pkg::ST_DONE : pnaf_pkg::ST_ROOT;
      end
      pnaf_pkg::ST_ROOT:   if (step == 5'd31) state_next = pnaf_pkg::ST_DIVIDE;
      pnaf_pkg::ST_DIVIDE: if (step == 5'd31 && op == 2'd3) state_next = pnaf_pkg::ST_DOT;
      pnaf_pkg::ST_DOT:    if (step == 5'd3) state_next = pnaf_pkg::ST_DONE;
      pnaf_pkg::ST_DONE:   if (out_free) state_next = pnaf_pkg::ST_IDLE;
      default:             state_next = pnaf_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = coef[step[1:0]];
    mul_b = coef[step[1:0]];
    if (state == pnaf_pkg::ST_DOT) begin
      mul_a = 33'(res[step[1:0]]);
      mul_b = 33'(axis[(step[1:0] == 2'd3) ? 2'd0 : step[1:0]]);
    end
  end

  assign sum_total = sumsq + prod[63:0];

  // square root digit
  always_comb begin
    sq_try = {sq_rem[32:0], sq_val[63:62]};
    sq_trial = {1'b0, root, 2'b01};
  end

  // division step and setup
  always_comb begin
    dv_x = coef[op];
    dv_mag = dv_x[32] ? 32'(-dv_x) : 32'(dv_x);
    dv_num = (op == 2'd3) ? ({31'd0, dv_mag} << 16) : ({31'd0, dv_mag} << 30);
    dv_try = {dv_rem[31:0], dv_low[30]};
    dv_ge = (dv_try >= {1'b0, root});
    if (dv_sat) begin
      dv_result = dv_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      dv_result = dv_neg ? -{1'b0, quo[29:0], dv_ge} : {1'b0, quo[29:0], dv_ge};
    end
  end

  // filter decision
  always_comb begin
    dot_abs = dot[47] ? -dot : dot;
    case (pnaf_pkg::mode_t'(filter_mode))
      pnaf_pkg::MODE_PAR:  pass = !degen && (dot_abs > {3'd0, cos_limit, 29'd0});
      pnaf_pkg::MODE_PERP: pass = !degen && (dot_abs < {3'd0, sin_limit, 29'd0});
      default:             pass = 1'b1;
    endcase
    if (kept_count >= CntW'(MAX_PLANES)) pass = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnaf_pkg::ST_IDLE;
      step <= '0;
      op <= '0;
      filter_mode <= pnaf_pkg::MODE_ALL;
      axis[0] <= 16'sd0;
      axis[1] <= 16'sd0;
      axis[2] <= 16'sd16384;
      cos_limit <= 16'd32768;
      sin_limit <= 16'd0;
      kept_count <= '0;
      plane_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= (state_next != state) ? 5'd0 : step + 5'd1;
      if (state == pnaf_pkg::ST_DIVIDE && step == 5'd31) op <= op + 2'd1;
      if (cfg.valid) begin
        case (pnaf_pkg::reg_idx_t'(cfg.index))
          pnaf_pkg::REG_MODE:   filter_mode <= cfg.data[1:0];
          pnaf_pkg::REG_AXIS_X: axis[0] <= cfg.data;
          pnaf_pkg::REG_AXIS_Y: axis[1] <= cfg.data;
          pnaf_pkg::REG_AXIS_Z: axis[2] <= cfg.data;
          pnaf_pkg::REG_COS:    cos_limit <= cfg.data;
          pnaf_pkg::REG_SIN:    sin_limit <= cfg.data;
          default: ;
        endcase
      end
      if (plane_out.valid && plane_out.ready) plane_out.valid <= 1'b0;
      if (load_out) begin
        plane_out.valid <= 1'b1;
        if (pass) kept_count <= kept_count + CntW'(1);
        if (last_hold) kept_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (take_in) begin
      // face the viewpoint: flip every coefficient when c is positive
      if (!plane_in.coef_c[31] && plane_in.coef_c != 32'sd0) begin
        coef[0] <= -33'(plane_in.coef_a);
        coef[1] <= -33'(plane_in.coef_b);
        coef[2] <= -33'(plane_in.coef_c);
        coef[3] <= -33'(plane_in.coef_d);
      end else begin
        coef[0] <= 33'(plane_in.coef_a);
        coef[1] <= 33'(plane_in.coef_b);
        coef[2] <= 33'(plane_in.coef_c);
        coef[3] <= 33'(plane_in.coef_d);
      end
      last_hold <= plane_in.last_plane;
      for (int i = 0; i < 4; i++) res[i] <= 32'sd0;
      sumsq <= '0;
      degen <= 1'b0;
    end
    case (state)
      pnaf_pkg::ST_SQUARE: begin
        if (step != 5'd0) sumsq <= sum_total;
        if (step == 5'd3) begin
          degen <= (sum_total == 64'd0);
          sq_val <= sum_total;
          sq_rem <= '0;
          root <= '0;
        end
      end
      pnaf_pkg::ST_ROOT: begin
        sq_val <= {sq_val[61:0], 2'b00};
        if (sq_try >= sq_trial) begin
          sq_rem <= sq_try - sq_trial;
          root <= {root[30:0], 1'b1};
        end else begin
          sq_rem <= sq_try;
          root <= {root[30:0], 1'b0};
        end
      end
      pnaf_pkg::ST_DIVIDE: begin
        if (step == 5'd0) begin
          // quotient of 2^31 or more only happens for d: saturate it
          dv_rem <= {1'b0, dv_num[62:31]};
          dv_low <= dv_num[30:0];
          dv_sat <= ({1'b0, dv_num[62:31]} >= {1'b0, root});
          dv_neg <= dv_x[32];
          quo <= '0;
        end else begin
          dv_low <= {dv_low[29:0], 1'b0};
          dv_rem <= dv_ge ? dv_try - {1'b0, root} : dv_try;
          quo <= {quo[29:0], dv_ge};
          if (step == 5'd31) res[op] <= dv_result;
        end
      end
      pnaf_pkg::ST_DOT: begin
        if (step == 5'd0) dot <= '0;
        else dot <= dot + prod[47:0];
      end
      default: ;
    endcase
    if (load_out) begin
      plane_out.norm_a <= res[0];
      plane_out.norm_b <= res[1];
      plane_out.norm_c <= res[2];
      plane_out.norm_d <= res[3];
      plane_out.kept <= pass;
      plane_out.slot <= pass ? pnaf_pkg::SlotW'(kept_count) : '0;
      plane_out.degenerate <= degen;
      plane_out.last_out <= last_hold;
    end
  end

`ifndef SYNTH
  a_c_not_positive: assert property (@(posedge clk) disable iff (rst)
    plane_out.valid |-> (plane_out.norm_c[31] || plane_out.norm_c == 32'sd0))
    else $error("normal z component positive");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (plane_out.valid && plane_out.degenerate) |->
      (plane_out.norm_a == 32'sd0 && plane_out.norm_b == 32'sd0 &&
       plane_out.norm_c == 32'sd0 && plane_out.norm_d == 32'sd0))
    else $error("degenerate result not zero");
  a_start: assert property (@(posedge clk) disable iff (rst)
    take_in |=> (state == pnaf_pkg::ST_SQUARE))
    else $error("accepted item did not start");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CntW'(MAX_PLANES))
    else $error("slot count past limit");
`endif

endmodule

[test/pnaf_tb_if.sv]
`timescale 1ns / 100ps
// Testbench item types for plane items and result items.
package pnaf_tb_pkg;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               last;
  } plane_t;

  typedef struct packed {
    logic signed [31:0] na;
    logic signed [31:0] nb;
    logic signed [31:0] nc;
    logic signed [31:0] nd;
    logic               kept;
    logic [7:0]         slot;
    logic               degen;
    logic               last;
  } norm_t;
endpackage

[test/plane_normalize_axis_filter_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the plane normalize and axis filter block.
module plane_normalize_axis_filter_tb;

  localparam int MaxPlanes = 256;
  localparam int IdleLimit = 20000;

  logic clk;
  logic rst;
  pnaf_plane_if  pin ();
  pnaf_result_if pout ();
  pnaf_cfg_if    cfg ();

  plane_normalize_axis_filter #(.MAX_PLANES(MaxPlanes)) dut (
    .clk(clk), .rst(rst), .plane_in(pin.sink), .plane_out(pout.source), .cfg(cfg.sink)
  );

  pnaf_tb_pkg::plane_t plane_q[$];
  pnaf_tb_pkg::norm_t  norm_q[$];
  logic [1:0]         m_mode;
  logic signed [15:0] m_ax, m_ay, m_az;
  logic [15:0]        m_cos, m_sin;
  int unsigned        m_count;
  int  errors;
  int  idle_cycles;
  bit  stall_on;
  bit  hold_send;
  bit  in_taken;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_trunc(longint x, int sh, logic [63:0] len);
    logic [63:0] mag, q;
    mag = x < 0 ? -x : x;
    q = (mag << sh) / len;
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Predict the normalized plane and update the kept count.
  function automatic pnaf_tb_pkg::norm_t normalize_plane(pnaf_tb_pkg::plane_t p);
    pnaf_tb_pkg::norm_t r;
    longint a, b, c, d, na, nb, nc, nd, dot;
    logic [63:0] sumsq, len;
    bit pass;
    a = p.a; b = p.b; c = p.c; d = p.d;
    na = 0; nb = 0; nc = 0; nd = 0;
    if (c > 0) begin
      a = -a; b = -b; c = -c; d = -d;
    end
    sumsq = a * a + b * b + c * c;
    r.degen = (sumsq == 0);
    if (!r.degen) begin
      len = root_floor(sumsq);
      na = div_trunc(a, 30, len);
      nb = div_trunc(b, 30, len);
      nc = div_trunc(c, 30, len);
      nd = div_trunc(d, 16, len);
      if (nd > 64'sd2147483647) nd = 64'sd2147483647;
      if (nd < -64'sd2147483648) nd = -64'sd2147483648;
    end
    if (m_mode == pnaf_pkg::MODE_PAR || m_mode == pnaf_pkg::MODE_PERP) begin
      dot = na * longint'(m_ax) + nb * longint'(m_ay) + nc * longint'(m_az);
      if (dot < 0) dot = -dot;
      if (r.degen) pass = 0;
      else if (m_mode == pnaf_pkg::MODE_PAR) pass = dot > longint'(m_cos) * 536870912;
      else pass = dot < longint'(m_sin) * 536870912;
    end else begin
      pass = 1;
    end
    if (pass && m_count >= MaxPlanes) pass = 0;
    r.slot = 0;
    if (pass) begin
      r.slot = m_count[7:0];
      m_count++;
    end
    if (p.last) m_count = 0;
    r.na = na[31:0]; r.nb = nb[31:0]; r.nc = nc[31:0]; r.nd = nd[31:0];
    r.kept = pass;
    r.last = p.last;
    return r;
  endfunction

  // Driver: present queued items, idling at random while stalls are on; advance once an item is taken.
  always @(negedge clk) begin
    if (rst) begin
      pin.valid <= 0;
    end else if (!pin.valid || in_taken) begin
      if (plane_q.size() > 0 && !hold_send && (!stall_on || $urandom_range(99) >= 35)) begin
        {pin.coef_a, pin.coef_b, pin.coef_c, pin.coef_d, pin.last_plane} <= plane_q[0];
        pin.valid <= 1;
      end else begin
        pin.valid <= 0;
      end
    end
    pout.ready <= rst ? 1'b0 : (!stall_on || $urandom_range(99) >= 35);
  end

  // Monitor: predict on accepted inputs, check accepted results.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 0;
    end else begin
      in_taken <= pin.valid && pin.ready;
      if ((pin.valid && pin.ready) || (pout.valid && pout.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (pin.valid && pin.ready) begin
        norm_q.insert(norm_q.size(), normalize_plane(plane_q.pop_front()));
      end
      if (pout.valid && pout.ready) begin
        pnaf_tb_pkg::norm_t got, want;
        got = {pout.norm_a, pout.norm_b, pout.norm_c, pout.norm_d, pout.kept, pout.slot,
               pout.degenerate, pout.last_out};
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected result exp none got %h", $time, got);
          errors++;
        end else begin
          want = norm_q.pop_front();
          if (got.na !== want.na) $display("%0t: norm_a exp %h got %h", $time, want.na, got.na);
          if (got.nb !== want.nb) $display("%0t: norm_b exp %h got %h", $time, want.nb, got.nb);
          if (got.nc !== want.nc) $display("%0t: norm_c exp %h got %h", $time, want.nc, got.nc);
          if (got.nd !== want.nd) $display("%0t: norm_d exp %h got %h", $time, want.nd, got.nd);
          if (got.kept !== want.kept)
            $display("%0t: kept exp %b got %b", $time, want.kept, got.kept);
          if (got.slot !== want.slot)
            $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
          if (got.degen !== want.degen)
            $display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
          if (got.last !== want.last)
            $display("%0t: last_out exp %b got %b", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      if (idle_cycles > IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(pnaf_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      pnaf_pkg::REG_MODE:   m_mode = val[1:0];
      pnaf_pkg::REG_AXIS_X: m_ax = val;
      pnaf_pkg::REG_AXIS_Y: m_ay = val;
      pnaf_pkg::REG_AXIS_Z: m_az = val;
      pnaf_pkg::REG_COS:    m_cos = val;
      pnaf_pkg::REG_SIN:    m_sin = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic drain();
    wait (plane_q.size() == 0 && norm_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(65535) - 32768;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  task automatic add_plane(logic [31:0] a, b, c, d, logic last);
    pnaf_tb_pkg::plane_t p;
    p = {a, b, c, d, last};
    plane_q.insert(plane_q.size(), p);
  endtask

  task automatic random_set(int n, bit big);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        add_plane(0, 0, 0, rand_coef(), k == n - 1);
      else if (big)
        add_plane(rand_coef(), rand_coef(), rand_coef(), rand_coef(), k == n - 1);
      else
        add_plane(32'($urandom_range(131072)) - 65536, 32'($urandom_range(131072)) - 65536,
                  32'($urandom_range(131072)) - 65536, rand_coef(), k == n - 1);
    end
  endtask

  initial begin
    int ph;
    rst = 1;
    errors = 0; idle_cycles = 0; stall_on = 0; hold_send = 0; in_taken = 0;
    pin.valid = 0; pin.coef_a = 0; pin.coef_b = 0; pin.coef_c = 0; pin.coef_d = 0;
    pin.last_plane = 0; pout.ready = 0; cfg.valid = 0; cfg.index = pnaf_pkg::REG_MODE;
    cfg.data = 0;
    m_mode = pnaf_pkg::MODE_ALL; m_ax = 0; m_ay = 0; m_az = 16384; m_cos = 16'h8000;
    m_sin = 0;
    m_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: extremes, zero normal, sign flip, saturating offset
    add_plane(0, 0, 0, 0, 0);
    add_plane(0, 0, 0, 32'h7fff_ffff, 0);
    add_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    add_plane(0, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
    add_plane(0, 0, 1, 32'h8000_0000, 0);
    add_plane(1, 0, 0, 32'h7fff_ffff, 0);
    add_plane(0, 32'hffff_ffff, 0, 32'h0001_0000, 0);
    add_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 1);
    drain();

    write_reg(pnaf_pkg::REG_MODE, pnaf_pkg::MODE_PAR);
    write_reg(pnaf_pkg::REG_COS, 16'd30000);
    add_plane(0, 0, 32'h0001_0000, 5, 0);
    add_plane(32'h0001_0000, 0, 0, 5, 0);
    add_plane(0, 0, 0, 5, 0);
    add_plane(0, 0, 32'hffff_0000, 5, 1);
    drain();
    write_reg(pnaf_pkg::REG_MODE, pnaf_pkg::MODE_PERP);
    write_reg(pnaf_pkg::REG_SIN, 16'h8000);
    add_plane(0, 0, 32'h0001_0000, 5, 0);
    add_plane(32'h0001_0000, 0, 0, 5, 0);
    add_plane(0, 0, 0, 5, 1);
    drain();
    write_reg(pnaf_pkg::REG_MODE, pnaf_pkg::MODE_ALT);
    add_plane(0, 0, 0, 1, 0);
    add_plane(3, 4, 0, 1, 1);
    drain();

    // overflow of the kept count in keep-all mode
    write_reg(pnaf_pkg::REG_MODE, pnaf_pkg::MODE_ALL);
    random_set(260, 0);
    drain();

    stall_on = 1;
    for (ph = 0; ph < 24; ph++) begin
      write_reg(pnaf_pkg::REG_MODE, $urandom_range(3));
      write_reg(pnaf_pkg::REG_AXIS_X, ph == 0 ? 16'h8000 : ph == 1 ? 16'h7fff : 16'($urandom));
      write_reg(pnaf_pkg::REG_AXIS_Y, ph == 0 ? 16'h8000 : 16'($urandom_range(32768) - 16384));
      write_reg(pnaf_pkg::REG_AXIS_Z, ph == 1 ? 16'h7fff : 16'($urandom_range(32768) - 16384));
      write_reg(pnaf_pkg::REG_COS, ph == 2 ? 16'h0 : 16'($urandom_range(32768)));
      write_reg(pnaf_pkg::REG_SIN, ph == 2 ? 16'h8000 : 16'($urandom_range(32768)));
      if (ph == 5) stall_on = 0;
      if (ph == 7) stall_on = 1;
      random_set($urandom_range(5, 20), 0);
      random_set($urandom_range(5, 20), 1);
      random_set($urandom_range(1, 5), 0);
      if (ph == 8) begin
        // hold off until every result has come, then send more
        wait (plane_q.size() == 0);
        hold_send = 1;
        wait (norm_q.size() == 0);
        hold_send = 0;
        random_set(10, 1);
      end
      drain();
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

[plane_normalize_axis_filter.f]
hdl/pnaf_pkg.sv
hdl/pnaf_if.sv
hdl/plane_normalize_axis_filter.sv
test/pnaf_tb_if.sv
test/plane_normalize_axis_filter_tb.sv
